// ----- design/mwo_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the oscillator mixer.
package mwo_pkg;

    localparam int PHASE_BITS = 32;
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_DEPTH_BITS = $clog2(SINE_DEPTH);
    localparam int ROM_IDX_W = SINE_DEPTH_BITS + 1;
    localparam int SAMPLE_W = 32;
    localparam int WAVE_W = 17;
    localparam int AMP_W = 15;
    localparam int GAIN_W = 16;
    localparam int SCALED_W = AMP_W + GAIN_W;
    localparam int PROD_W = 48;
    localparam int FRAC_SHIFT = 30;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd32768;

    typedef enum logic [1:0] {
        WAVE_SQUARE = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_SINE   = 2'd2,
        WAVE_OFF    = 2'd3
    } t_wave;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVEFORM   = 2'd0,
        CFG_PHASE_STEP = 2'd1,
        CFG_VELOCITY   = 2'd2,
        CFG_MIX_GAIN   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_wave              waveform;
        logic [31:0]        phase_step;
        logic [6:0]         velocity;
        logic [GAIN_W-1:0]  mix_gain;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       eob;
        t_wave                      kind;
        logic signed [WAVE_W-1:0]   fixed_wave;
        logic [ROM_IDX_W-1:0]       rom_idx;
        logic                       negate;
    } t_item;

    typedef logic [15:0] t_sine_rom [0:SINE_DEPTH];

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] s;
        logic signed [63:0] v;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
            x2 = (x * x) >> FRAC_SHIFT;
            s = $signed(x);
            term = ((x * x2) >> FRAC_SHIFT) / 6;
            s = s - $signed(term);
            term = ((term * x2) >> FRAC_SHIFT) / 20;
            s = s + $signed(term);
            term = ((term * x2) >> FRAC_SHIFT) / 42;
            s = s - $signed(term);
            term = ((term * x2) >> FRAC_SHIFT) / 72;
            s = s + $signed(term);
            if (s < 0) begin
                s = 0;
            end
            v = (s * 64'sd32767 + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
            if (v > 64'sd32767) begin
                v = 64'sd32767;
            end
            rom[k] = v[15:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

// ----- design/multiwave_oscillator_mixer_core.sv -----
// Top level of the oscillator mixer: configuration registers, front end, queue and back end.
//
// Usage: the input channel (i_in_valid, o_in_stall) carries one mix sample per item,
// with a note-start flag that clears the phase before the sample and an end-of-buffer
// flag that is copied to the result. The output channel (o_out_valid, i_out_stall)
// returns exactly one result per item, in order: the sample plus the scaled square,
// sawtooth or sine value (zero when the waveform is off), saturated to 32-bit signed.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data, by the user
// only while no item is in flight (the block has no check for it); index 0 waveform,
// 1 phase step, 2 velocity, 3 mix gain. An item passes through the queue, the sine
// table read with the gain product, the waveform multiply, then round and saturate.
// Throughput: one item per cycle while the queue is not full; the phase accumulator
// needs one add per item. When the receiver stalls, the back pipeline holds and the
// four-entry queue fills; o_in_stall rises only when the queue is full.
// Reset (synchronous, active low) clears the phase, the queue and all valid flags,
// and sets waveform square, phase step 0, velocity 0 and mix gain 1.0. The sine
// table is a constant, so no fill pass follows reset.
module multiwave_oscillator_mixer_core import mwo_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_in_sample,
    input  logic                       i_note_start,
    input  logic                       i_end_of_buffer,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic                       o_last_of_buffer
);

    t_cfg  r_cfg;
    logic  push;
    logic  pop;
    logic  queue_full;
    logic  queue_empty;
    t_item front_item;
    t_item queue_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.waveform <= WAVE_SQUARE;
            r_cfg.phase_step <= '0;
            r_cfg.velocity <= '0;
            r_cfg.mix_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_WAVEFORM:   r_cfg.waveform <= t_wave'(i_cfg_data[1:0]);
                CFG_PHASE_STEP: r_cfg.phase_step <= i_cfg_data;
                CFG_VELOCITY:   r_cfg.velocity <= i_cfg_data[6:0];
                CFG_MIX_GAIN:   r_cfg.mix_gain <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mwo_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_in_sample     (i_in_sample),
        .i_note_start    (i_note_start),
        .i_end_of_buffer (i_end_of_buffer),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_item          (front_item)
    );

    mwo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (queue_empty)
    );

    mwo_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_item           (queue_item),
        .i_empty          (queue_empty),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_sample     (o_out_sample),
        .o_last_of_buffer (o_last_of_buffer)
    );

endmodule

// ----- design/mwo_front.sv -----
// Front end: accepts items, runs the phase accumulator and classifies the waveform lookup.
module mwo_front import mwo_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_in_sample,
    input  logic                       i_note_start,
    input  logic                       i_end_of_buffer,
    input  logic                       i_queue_full,
    output logic                       o_push,
    output t_item                      o_item
);

    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      n_phase;
    logic [PHASE_BITS-1:0]      cur_phase;
    logic [1:0]                 quad;
    logic [SINE_DEPTH_BITS-1:0] frac_idx;
    logic                       accept;

    assign o_in_stall = i_queue_full;
    assign accept = i_in_valid && !i_queue_full;
    assign o_push = accept;

    assign cur_phase = i_note_start ? '0 : r_phase;
    assign n_phase = cur_phase + PHASE_BITS'(i_cfg.phase_step);
    assign quad = cur_phase[PHASE_BITS-1 -: 2];
    assign frac_idx = cur_phase[PHASE_BITS-3 -: SINE_DEPTH_BITS];

    always_comb begin
        o_item.sample = i_in_sample;
        o_item.eob = i_end_of_buffer;
        o_item.kind = i_cfg.waveform;
        o_item.negate = quad[1];
        o_item.rom_idx = quad[0] ? ROM_IDX_W'(SINE_DEPTH) - {1'b0, frac_idx}
                                 : {1'b0, frac_idx};
        case (i_cfg.waveform)
            WAVE_SQUARE: begin
                o_item.fixed_wave = cur_phase[PHASE_BITS-1] ? 17'sd32768 : -17'sd32768;
            end
            WAVE_SAW: begin
                o_item.fixed_wave = WAVE_W'($signed({~cur_phase[PHASE_BITS-1],
                                                     cur_phase[PHASE_BITS-2 -: 15]}));
            end
            default: begin
                o_item.fixed_wave = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

`ifndef NO_ASSERTIONS
    a_note_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_note_start |=> r_phase == PHASE_BITS'($past(i_cfg.phase_step)))
        else $error("phase after a note start is not one step");
`endif

endmodule

// ----- design/mwo_queue.sv -----
// Short item queue between the front end and the back end.
module mwo_queue import mwo_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_full = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("item pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("item popped from an empty queue");
    a_count_tracks_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < QUEUE_CNT_W'(QUEUE_DEPTH) |->
            QUEUE_PTR_W'(r_wr_ptr - r_rd_ptr) == r_count[QUEUE_PTR_W-1:0])
        else $error("queue count disagrees with pointers");
`endif

endmodule

// ----- design/mwo_back.sv -----
// Back end: sine lookup, gain multiply, rounding, saturating add and output register.
module mwo_back import mwo_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  t_item                      i_item,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic                       o_last_of_buffer
);

    logic                       en;
    logic [AMP_W-1:0]           amp;
    logic                       r_s1_valid;
    t_wave                      r_s1_kind;
    logic signed [WAVE_W-1:0]   r_s1_fixed;
    logic                       r_s1_neg;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic                       r_s1_eob;
    logic [15:0]                r_rom_q;
    logic [SCALED_W-1:0]        r_s1_scaled;
    logic signed [WAVE_W-1:0]   wave;
    logic                       r_s2_valid;
    logic signed [SAMPLE_W-1:0] r_s2_sample;
    logic                       r_s2_eob;
    logic signed [PROD_W-1:0]   r_s2_prod;
    logic signed [PROD_W-1:0]   adj;
    logic signed [SAMPLE_W:0]   sum;
    logic signed [SAMPLE_W-1:0] sat;
    logic                       r_out_valid;

    assign en = !r_out_valid || !i_out_stall;
    assign o_pop = en && !i_empty;
    assign o_out_valid = r_out_valid;

    // velocity * 32767 / 127 equals 258 * velocity, plus one at full velocity.
    assign amp = AMP_W'({i_cfg.velocity, 8'd0}) + AMP_W'({i_cfg.velocity, 1'b0})
               + AMP_W'(i_cfg.velocity == 7'd127);

    always_comb begin
        if (r_s1_kind == WAVE_SINE) begin
            wave = r_s1_neg ? -$signed({1'b0, r_rom_q}) : $signed({1'b0, r_rom_q});
        end else begin
            wave = r_s1_fixed;
        end
    end

    always_comb begin
        adj = r_s2_prod + (r_s2_prod[PROD_W-1] ? PROD_W'((64'd1 << FRAC_SHIFT) - 64'd1)
                                               : PROD_W'(0));
        sum = {r_s2_sample[SAMPLE_W-1], r_s2_sample}
            + (SAMPLE_W+1)'($signed(adj[PROD_W-1:FRAC_SHIFT]));
        if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
            sat = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rom_q <= SINE_ROM[i_item.rom_idx];
            r_s1_kind <= i_item.kind;
            r_s1_fixed <= i_item.fixed_wave;
            r_s1_neg <= i_item.negate;
            r_s1_sample <= i_item.sample;
            r_s1_eob <= i_item.eob;
            r_s1_scaled <= amp * i_cfg.mix_gain;
            r_s2_sample <= r_s1_sample;
            r_s2_eob <= r_s1_eob;
            r_s2_prod <= $signed({1'b0, r_s1_scaled}) * wave;
            o_out_sample <= sat;
            o_last_of_buffer <= r_s2_eob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= o_pop;
            r_s2_valid <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s1_valid) && $stable(r_s2_valid) && $stable(r_s2_prod))
        else $error("back pipeline moved while the output was stalled");
`endif

endmodule
